@@ design/iop_pkg.sv @@
// shared types and constants of the interval overlap join
package iop_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int COORD_BITS_DEF  = 32;

	localparam int FIELD_W = 32;   // width of the coordinate and counter fields
	localparam int SIDX_W  = 6;    // width of the stored index field

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_PROBE  = 2'd1,
		CMD_REPORT = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic load;     // write the cell whose index equals the fill count
		logic capture;  // compare the probe and latch the hit flag
		logic shift;    // move hit flags one cell toward the head
	} cell_ctl_t;

endpackage

@@ design/iop_req_if.sv @@
// request channel of the interval overlap join
interface iop_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] start_req;
	logic [31:0] length;

	modport source (output valid, output command, output start_req, output length,
		input ready);
	modport sink (input valid, input command, input start_req, input length,
		output ready);
endinterface

@@ design/iop_rsp_if.sv @@
// result channel of the interval overlap join
interface iop_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] probe_index;
	logic [5:0]  stored_index;
	logic [31:0] pair_total;
	logic        last;

	modport source (output valid, output kind, output probe_index, output stored_index,
		output pair_total, output last, input ready);
	modport sink (input valid, input kind, input probe_index, input stored_index,
		input pair_total, input last, output ready);
endinterface

@@ design/iop_cell.sv @@
// one store cell: holds an interval, compares a probe, passes its hit flag on
module iop_cell #(
	parameter int COORD_BITS = iop_pkg::COORD_BITS_DEF,
	parameter int CNT_W      = 7,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iop_pkg::cell_ctl_t    ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [COORD_BITS-1:0] wr_start,
	input  logic [COORD_BITS:0]   wr_end,
	input  logic [COORD_BITS-1:0] probe_start,
	input  logic [COORD_BITS:0]   probe_end,
	input  logic                  hit_in,
	output logic                  hit
);

	logic [COORD_BITS-1:0] start_q;
	logic [COORD_BITS:0]   end_q;
	logic                  hit_q;
	logic                  match;

	assign match = ({1'b0, probe_start} <= end_q) && (probe_end >= {1'b0, start_q})
		&& (CNT_W'(INDEX) < count);

	always_ff @(posedge clk) begin
		if (ctl.load && (count == CNT_W'(INDEX))) begin
			start_q <= wr_start;
			end_q   <= wr_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.capture) begin
			hit_q <= match;
		end else if (ctl.shift) begin
			hit_q <= hit_in;
		end
	end

	assign hit = hit_q;

endmodule

@@ design/iop_chain.sv @@
// row of store cells; hit flags travel toward cell zero one step per shift
module iop_chain #(
	parameter int STORE_DEPTH = iop_pkg::STORE_DEPTH_DEF,
	parameter int COORD_BITS  = iop_pkg::COORD_BITS_DEF,
	parameter int CNT_W       = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iop_pkg::cell_ctl_t    ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [COORD_BITS-1:0] wr_start,
	input  logic [COORD_BITS:0]   wr_end,
	input  logic [COORD_BITS-1:0] probe_start,
	input  logic [COORD_BITS:0]   probe_end,
	output logic                  head_hit
);

	logic hit_w [STORE_DEPTH];

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		logic nbr_hit;
		if (i == STORE_DEPTH - 1) begin : g_tail
			assign nbr_hit = 1'b0;
		end else begin : g_mid
			assign nbr_hit = hit_w[i+1];
		end

		iop_cell #(
			.COORD_BITS (COORD_BITS),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.count       (count),
			.wr_start    (wr_start),
			.wr_end      (wr_end),
			.probe_start (probe_start),
			.probe_end   (probe_end),
			.hit_in      (nbr_hit),
			.hit         (hit_w[i])
		);
	end

	assign head_hit = hit_w[0];

endmodule

@@ design/interval_overlap_pairs.sv @@
// top level of the brute-force interval overlap join
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | command, start_req, length
//  rsp     | out | valid / ready | kind, probe_index, stored_index, pair_total, last
//
// load and clear complete on acceptance; a report passes through the report state,
// which loads the pair total into the output register once that register is free
// a probe compares in all cells at once, shifts the hit flags through the cell row,
// then flushes the held result; a probe of an empty store skips the scan
// reset zeroes the fill count, probe and pair counters and all control; the stored
// intervals are not cleared, and only entries below the fill count are ever used
// the shift pauses while a hit reaches the head with a result already held and the
// output register full and not being taken
module interval_overlap_pairs #(
	parameter int STORE_DEPTH = iop_pkg::STORE_DEPTH_DEF,
	parameter int COORD_BITS  = iop_pkg::COORD_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	iop_req_if.sink   req,
	iop_rsp_if.source rsp
);

	localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int IN_BITS = (COORD_BITS < iop_pkg::FIELD_W) ? COORD_BITS : iop_pkg::FIELD_W;
	localparam int SI_BITS = (IDX_W < iop_pkg::SIDX_W) ? IDX_W : iop_pkg::SIDX_W;
	localparam logic [iop_pkg::FIELD_W-1:0] TOTAL_MAX = '1;

	// one-hot sequencer states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_FLUSH  = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// fill count and counters
	logic [CNT_W-1:0]            count_q;
	logic [iop_pkg::FIELD_W-1:0] probe_ctr_q;
	logic [iop_pkg::FIELD_W-1:0] pair_total_q;
	logic [iop_pkg::FIELD_W-1:0] cur_probe_q;   // ordinal of the probe being scanned
	logic [IDX_W-1:0]            scan_idx_q;    // stored index now at the head cell

	// one result held back so that the final one can carry last
	logic                        pend_valid_q;
	logic [IDX_W-1:0]            pend_idx_q;
	logic [iop_pkg::FIELD_W-1:0] pend_total_q;

	// output register
	logic                        out_valid_q;
	logic                        out_kind_q;
	logic [iop_pkg::FIELD_W-1:0] out_probe_q;
	logic [iop_pkg::SIDX_W-1:0]  out_sidx_q;
	logic [iop_pkg::FIELD_W-1:0] out_total_q;
	logic                        out_last_q;

	logic                        accept;
	iop_pkg::cmd_t               cmd;
	logic [COORD_BITS-1:0]       in_start;
	logic [COORD_BITS-1:0]       in_len;
	logic [COORD_BITS:0]         in_end;
	iop_pkg::cell_ctl_t          ctl;
	logic                        head_hit;
	logic                        out_free;
	logic                        step;
	logic                        scan_end;
	logic                        is_idle;
	logic                        is_scan;
	logic                        is_flush;
	logic                        is_report;
	logic [iop_pkg::FIELD_W-1:0] total_inc;
	logic [iop_pkg::SIDX_W-1:0]  pend_sidx;

	assign is_idle   = (state_q == ST_IDLE);
	assign is_scan   = (state_q == ST_SCAN);
	assign is_flush  = (state_q == ST_FLUSH);
	assign is_report = (state_q == ST_REPORT);

	// one request at a time: taken only while idle
	assign req.ready = is_idle;
	assign accept    = req.valid && is_idle;
	assign cmd       = iop_pkg::cmd_t'(req.command);

	// coordinates masked to the configured width, end kept one bit wider
	assign in_start = COORD_BITS'(req.start_req[IN_BITS-1:0]);
	assign in_len   = COORD_BITS'(req.length[IN_BITS-1:0]);
	assign in_end   = {1'b0, in_start} + {1'b0, in_len};

	assign out_free = !out_valid_q || rsp.ready;

	// a head hit needs room for the held result before it can take its place
	assign step     = is_scan && (!head_hit || !pend_valid_q || out_free);
	assign scan_end = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);

	assign total_inc = (pair_total_q == TOTAL_MAX) ? pair_total_q
		: pair_total_q + iop_pkg::FIELD_W'(1);

	assign pend_sidx = iop_pkg::SIDX_W'(pend_idx_q[SI_BITS-1:0]);

	assign ctl.load    = accept && (cmd == iop_pkg::CMD_LOAD)
		&& (count_q < CNT_W'(STORE_DEPTH));
	assign ctl.capture = accept && (cmd == iop_pkg::CMD_PROBE);
	assign ctl.shift   = step;

	iop_chain #(
		.STORE_DEPTH (STORE_DEPTH),
		.COORD_BITS  (COORD_BITS),
		.CNT_W       (CNT_W)
	) u_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.count       (count_q),
		.wr_start    (in_start),
		.wr_end      (in_end),
		.probe_start (in_start),
		.probe_end   (in_end),
		.head_hit    (head_hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						iop_pkg::CMD_PROBE: begin
							// an empty store gives nothing to scan
							state_d = (count_q == '0) ? ST_IDLE : ST_SCAN;
						end
						iop_pkg::CMD_REPORT: begin
							state_d = ST_REPORT;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (step && scan_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer, counters and held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			probe_ctr_q  <= '0;
			pair_total_q <= '0;
			scan_idx_q   <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (cmd == iop_pkg::CMD_CLEAR)) begin
				count_q      <= '0;
				probe_ctr_q  <= '0;
				pair_total_q <= '0;
			end
			if (ctl.load) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctl.capture) begin
				probe_ctr_q <= probe_ctr_q + iop_pkg::FIELD_W'(1);
				scan_idx_q  <= '0;
			end
			if (step) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (head_hit) begin
					pair_total_q <= total_inc;
					pend_valid_q <= 1'b1;
				end
			end
			if (is_flush && pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload of the held result and of the probe in flight
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cur_probe_q <= probe_ctr_q;
		end
		if (step && head_hit) begin
			pend_idx_q   <= scan_idx_q;
			pend_total_q <= total_inc;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((step && head_hit && pend_valid_q)
			|| (is_flush && pend_valid_q && out_free)
			|| (is_report && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((step && head_hit && pend_valid_q) || (is_flush && pend_valid_q && out_free)) begin
			// pair result: last only when the scan is over
			out_kind_q  <= 1'b0;
			out_probe_q <= cur_probe_q;
			out_sidx_q  <= pend_sidx;
			out_total_q <= pend_total_q;
			out_last_q  <= is_flush;
		end else if (is_report && out_free) begin
			out_kind_q  <= 1'b1;
			out_probe_q <= '0;
			out_sidx_q  <= '0;
			out_total_q <= pair_total_q;
			out_last_q  <= 1'b1;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.probe_index  = out_probe_q;
	assign rsp.stored_index = out_sidx_q;
	assign rsp.pair_total   = out_total_q;
	assign rsp.last         = out_last_q;

`ifndef ASSERT_OFF
	// a held result never outlives its probe
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		is_idle |-> !pend_valid_q)
		else $error("held result left over in idle");

	// the scan never looks past the filled part of the store
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		is_scan |-> (CNT_W'(scan_idx_q) < count_q))
		else $error("scan index beyond fill count");

	// the pair total only grows between clears
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && (cmd == iop_pkg::CMD_CLEAR)) |=> (pair_total_q >= $past(pair_total_q)))
		else $error("pair total went down without a clear");
`endif

endmodule
